[hdl/nfps_pkg.sv]
// ----------------------------------------------------------------------------
// nfps_pkg
// Shared types and constants for the nearest four point selector.
// ----------------------------------------------------------------------------
`default_nettype none

package nfps_pkg;

  // Field widths
  localparam int COORD_W = 16;   // unsigned 12.4 coordinate
  localparam int SQ_W    = 32;   // square of a 12.4 difference, 24.8
  localparam int DIST_W  = 33;   // sum of two squares, 25.8
  localparam int RANK_W  = 2;

  // Default number of kept neighbors
  localparam int KEEP_COUNT_DEF = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAND_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAND_Y = 1'b1;

  // One kept point
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIST_W-1:0]  dsq;
  } point_t;

  // Point after the squaring stage
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SQ_W-1:0]    dx2;
    logic [SQ_W-1:0]    dy2;
    logic               last;
  } sq_point_t;

  // Handshake between squaring stage and list stage
  typedef struct packed {
    logic valid;
    logic go;
  } stage_ctl_t;

endpackage : nfps_pkg

`default_nettype wire

[hdl/nfps_dist.sv]
// ----------------------------------------------------------------------------
// nfps_dist
// Input register stage: absolute differences to the candidate point and
// their squares, registered with the point coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module nfps_dist
  import nfps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               take,
  input  wire logic [COORD_W-1:0] point_x,
  input  wire logic [COORD_W-1:0] point_y,
  input  wire logic               final_point,
  input  wire logic [COORD_W-1:0] cand_x,
  input  wire logic [COORD_W-1:0] cand_y,
  input  wire logic               go,
  output logic                    valid,
  output sq_point_t               data
);

  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic               valid_r;
  sq_point_t          data_r;

  // Exact magnitudes of the differences
  always_comb begin
    dx = (point_x >= cand_x) ? (point_x - cand_x) : (cand_x - point_x);
    dy = (point_y >= cand_y) ? (point_y - cand_y) : (cand_y - point_y);
  end

  // Stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (go) begin
      valid_r <= 1'b0;
    end
  end

  // Payload: two 16x16 squarers
  always_ff @(posedge clk) begin
    if (take) begin
      data_r.x    <= point_x;
      data_r.y    <= point_y;
      data_r.dx2  <= SQ_W'(dx) * SQ_W'(dx);
      data_r.dy2  <= SQ_W'(dy) * SQ_W'(dy);
      data_r.last <= final_point;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule : nfps_dist

`default_nettype wire

[hdl/nfps_list.sv]
// ----------------------------------------------------------------------------
// nfps_list
// Ordered list of the nearest points. One insert per cycle while not held:
// distance sum, parallel compares against every slot, then a one-place shift.
// ----------------------------------------------------------------------------
`default_nettype none

module nfps_list
  import nfps_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF,
  parameter int CNT_W      = $clog2(KEEP_COUNT + 1)
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire stage_ctl_t ctl,
  input  wire sq_point_t  pt,
  output logic            dr_load,
  output logic [CNT_W-1:0] dr_count,
  output point_t          dr_pts [KEEP_COUNT]
);

  point_t           slot_r   [KEEP_COUNT];
  point_t           slot_nxt [KEEP_COUNT];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [CNT_W-1:0] fill_inc;
  logic [DIST_W-1:0] new_dsq;
  point_t           new_pt;
  logic [KEEP_COUNT-1:0] beat;
  logic [KEEP_COUNT-1:0] prior_beat;   // some earlier slot is beaten
  logic             any_beat;
  logic             not_full;
  logic             go;

  assign go = ctl.valid && ctl.go;

  // Distance of the incoming point
  always_comb begin
    new_dsq = DIST_W'(pt.dx2) + DIST_W'(pt.dy2);
    new_pt  = '{x: pt.x, y: pt.y, dsq: new_dsq};
  end

  assign not_full = (fill_r < CNT_W'(KEEP_COUNT));
  assign any_beat = prior_beat[KEEP_COUNT-1] | beat[KEEP_COUNT-1];
  assign fill_inc = fill_r + CNT_W'(not_full);

  // Per-slot compare and next content
  for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_slot
    assign beat[g] = (new_dsq != '0) && (CNT_W'(g) < fill_r) && (new_dsq < slot_r[g].dsq);

    if (g == 0) begin : g_first
      assign prior_beat[g] = 1'b0;
      always_comb begin
        if (beat[g] || (!any_beat && fill_r == CNT_W'(g))) begin
          slot_nxt[g] = new_pt;
        end else begin
          slot_nxt[g] = slot_r[g];
        end
      end
    end else begin : g_rest
      assign prior_beat[g] = prior_beat[g-1] | beat[g-1];
      always_comb begin
        if (prior_beat[g]) begin
          slot_nxt[g] = slot_r[g-1];
        end else if (beat[g] || (!any_beat && fill_r == CNT_W'(g))) begin
          slot_nxt[g] = new_pt;
        end else begin
          slot_nxt[g] = slot_r[g];
        end
      end
    end
  end

  // Final point empties the list after handing it over
  always_comb begin
    fill_nxt = fill_r;
    if (go) begin
      fill_nxt = pt.last ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Slot payload, no reset
  always_ff @(posedge clk) begin
    if (go) begin
      slot_r <= slot_nxt;
    end
  end

  // Handover to the output buffer
  assign dr_load  = go && pt.last;
  assign dr_count = fill_inc;
  assign dr_pts   = slot_nxt;

endmodule : nfps_list

`default_nettype wire

[hdl/nfps_drain.sv]
// ----------------------------------------------------------------------------
// nfps_drain
// Output buffer: holds a finished list and shifts it out one neighbor per
// taken result.
// ----------------------------------------------------------------------------
`default_nettype none

module nfps_drain
  import nfps_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF,
  parameter int CNT_W      = $clog2(KEEP_COUNT + 1),
  parameter int IDX_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1
)(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic [CNT_W-1:0] count,
  input  wire point_t           pts [KEEP_COUNT],
  input  wire logic             out_stall,
  output logic                  busy,
  output logic                  free,
  output logic                  out_valid,
  output point_t                head,
  output logic [RANK_W-1:0]     rank,
  output logic                  end_of_list
);

  point_t           buf_r [KEEP_COUNT];
  logic [CNT_W-1:0] left_r;
  logic [IDX_W-1:0] rank_r;
  logic             pop;

  assign busy      = (left_r != '0);
  assign out_valid = busy;
  assign pop       = busy && !out_stall;

  // Ready for a new list: empty, or the last neighbor leaves this cycle
  assign free      = !busy || (pop && left_r == CNT_W'(1));

  // Remaining count and rank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      rank_r <= '0;
    end else if (load) begin
      left_r <= count;
      rank_r <= '0;
    end else if (pop) begin
      left_r <= left_r - CNT_W'(1);
      rank_r <= rank_r + IDX_W'(1);
    end
  end

  // Shift line, head at entry zero
  for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_buf
    if (g == KEEP_COUNT - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (load) begin
          buf_r[g] <= pts[g];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (load) begin
          buf_r[g] <= pts[g];
        end else if (pop) begin
          buf_r[g] <= buf_r[g+1];
        end
      end
    end
  end

  assign head        = buf_r[0];
  assign rank        = RANK_W'(rank_r);
  assign end_of_list = (left_r == CNT_W'(1));

endmodule : nfps_drain

`default_nettype wire

[hdl/nearest_four_point_selector.sv]
// ----------------------------------------------------------------------------
// nearest_four_point_selector
// Keeps the KEEP_COUNT points nearest to a configured candidate point and
// emits them, nearest first, when a point marked final arrives.
// ----------------------------------------------------------------------------
// Takes one point per clock while in_stall is low. A point is registered with
// its two squared coordinate differences, then enters the kept list, where
// its squared distance is compared against all slots at once. A final point
// hands the whole list to an output buffer, which sends one neighbor per
// cycle while out_stall is low once the list is loaded into its registers;
// the list itself is free for the next set immediately. Input stalls only
// while a final point waits for the output buffer to hand out the last
// neighbor of the previous set; the new list loads in the cycle that
// neighbor is taken, so input and output of successive sets overlap.
// Candidate registers may be written
// only while the block is idle.
`default_nettype none

module nearest_four_point_selector
  import nfps_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // point input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [COORD_W-1:0]   in_point_x,
  input  wire logic [COORD_W-1:0]   in_point_y,
  input  wire logic                 in_final_point,
  // neighbor output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [COORD_W-1:0]        out_neighbor_x,
  output logic [COORD_W-1:0]        out_neighbor_y,
  output logic [DIST_W-1:0]         out_neighbor_dist_sq,
  output logic [RANK_W-1:0]         out_rank,
  output logic                      out_end_of_list,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(KEEP_COUNT + 1);

  logic [COORD_W-1:0] cand_x_r;
  logic [COORD_W-1:0] cand_y_r;
  logic               take;
  logic               a_valid;
  sq_point_t          a_data;
  stage_ctl_t         a_ctl;
  logic               dr_load;
  logic [CNT_W-1:0]   dr_count;
  point_t             dr_pts [KEEP_COUNT];
  logic               drain_busy;
  logic               drain_free;
  point_t             head;

  // Candidate registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_x_r <= '0;
      cand_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAND_X: cand_x_r <= cfg_data;
        CFG_CAND_Y: cand_y_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Flow control: only a final point can be held, waiting on the buffer
  always_comb begin
    a_ctl.valid = a_valid;
    a_ctl.go    = a_valid && (!a_data.last || drain_free);
    in_stall    = a_valid && !a_ctl.go;
    take        = in_valid && !in_stall;
  end

  nfps_dist u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .point_x     (in_point_x),
    .point_y     (in_point_y),
    .final_point (in_final_point),
    .cand_x      (cand_x_r),
    .cand_y      (cand_y_r),
    .go          (a_ctl.go),
    .valid       (a_valid),
    .data        (a_data)
  );

  nfps_list #(
    .KEEP_COUNT (KEEP_COUNT),
    .CNT_W      (CNT_W)
  ) u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (a_ctl),
    .pt       (a_data),
    .dr_load  (dr_load),
    .dr_count (dr_count),
    .dr_pts   (dr_pts)
  );

  nfps_drain #(
    .KEEP_COUNT (KEEP_COUNT),
    .CNT_W      (CNT_W)
  ) u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (dr_load),
    .count       (dr_count),
    .pts         (dr_pts),
    .out_stall   (out_stall),
    .busy        (drain_busy),
    .free        (drain_free),
    .out_valid   (out_valid),
    .head        (head),
    .rank        (out_rank),
    .end_of_list (out_end_of_list)
  );

  assign out_neighbor_x       = head.x;
  assign out_neighbor_y       = head.y;
  assign out_neighbor_dist_sq = head.dsq;

  // Input is held back only behind a busy output buffer
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (drain_busy && a_data.last))
    else $error("input stalled without a pending final point");

  // A list is loaded only once the previous one is out or leaving
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    dr_load |-> drain_free)
    else $error("output buffer loaded while busy");

  // After the last neighbor: idle, or a new set at its first rank
  a_end_drains : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_end_of_list) |=> (!out_valid || out_rank == '0))
    else $error("results continue after end of list");

  // Every set starts at rank zero
  a_first_rank : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_rank == '0))
    else $error("set does not start at rank zero");

endmodule : nearest_four_point_selector

`default_nettype wire

[tb/nfps_checker.sv]
// ----------------------------------------------------------------------------
// nfps_checker
// Watches the point, neighbor and configuration channels of the nearest four
// point selector. It keeps its own copy of the candidate point and the kept
// list, queues the neighbors that each final point should release, and
// compares every neighbor item that leaves the block, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module nfps_checker
  import nfps_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [COORD_W-1:0]   in_point_x,
  input  wire logic [COORD_W-1:0]   in_point_y,
  input  wire logic                 in_final_point,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [COORD_W-1:0]   out_neighbor_x,
  input  wire logic [COORD_W-1:0]   out_neighbor_y,
  input  wire logic [DIST_W-1:0]    out_neighbor_dist_sq,
  input  wire logic [RANK_W-1:0]    out_rank,
  input  wire logic                 out_end_of_list,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_W-1:0]   cfg_data,
  output int                        fail_count,
  output int                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIST_W-1:0]  dsq;
    logic [RANK_W-1:0]  rank;
    logic               eol;
  } neighbor_t;

  // Neighbors released by final points, oldest first
  neighbor_t neighbors_due[$];

  // Shadow of the candidate registers and the kept list
  logic [COORD_W-1:0] cand_x = '0;
  logic [COORD_W-1:0] cand_y = '0;
  logic [COORD_W-1:0] kept_x[KEEP_COUNT];
  logic [COORD_W-1:0] kept_y[KEEP_COUNT];
  logic [DIST_W:0]    kept_dist[KEEP_COUNT];
  int                 kept_count = 0;
  int                 errors = 0;

  assign fail_count = errors;

  // Place one accepted point in the kept list; on a final point release it
  task automatic rank_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic last);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [DIST_W:0]    dxw;
    logic [DIST_W:0]    dyw;
    logic [DIST_W:0]    d;
    int                 pos;
    int                 top;
    int                 i;
    bit                 found;
    neighbor_t          n;
    dx = (px >= cand_x) ? px - cand_x : cand_x - px;
    dy = (py >= cand_y) ? py - cand_y : cand_y - py;
    dxw = (DIST_W+1)'(dx);
    dyw = (DIST_W+1)'(dy);
    d = dxw * dxw + dyw * dyw;
    pos = kept_count;
    found = 1'b0;
    // zero distance never displaces; ties go behind kept points
    if (d != 0) begin
      for (i = 0; i < kept_count; i++) begin
        if (!found && d < kept_dist[i]) begin
          pos = i;
          found = 1'b1;
        end
      end
    end
    if (pos < kept_count) begin
      top = (kept_count < KEEP_COUNT) ? kept_count : KEEP_COUNT - 1;
      for (i = top; i > pos; i--) begin
        kept_x[i] = kept_x[i-1];
        kept_y[i] = kept_y[i-1];
        kept_dist[i] = kept_dist[i-1];
      end
      kept_x[pos] = px;
      kept_y[pos] = py;
      kept_dist[pos] = d;
      if (kept_count < KEEP_COUNT) kept_count++;
    end else if (kept_count < KEEP_COUNT) begin
      kept_x[kept_count] = px;
      kept_y[kept_count] = py;
      kept_dist[kept_count] = d;
      kept_count++;
    end
    if (last) begin
      for (i = 0; i < kept_count; i++) begin
        n.x = kept_x[i];
        n.y = kept_y[i];
        n.dsq = kept_dist[i][DIST_W-1:0];
        n.rank = RANK_W'(i);
        n.eol = (i == kept_count - 1);
        neighbors_due.insert(neighbors_due.size(), n);
      end
      kept_count = 0;
    end
  endtask

  task automatic report(input string field, input logic [DIST_W-1:0] exp_v,
                        input logic [DIST_W-1:0] act_v);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
    errors++;
  endtask

  // Everything is sampled at the edge, before the edge's updates land
  always @(posedge clk) begin : watch
    neighbor_t n;
    if (!rst_n) begin
      cand_x = '0;
      cand_y = '0;
      kept_count = 0;
      neighbors_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAND_X: cand_x = cfg_data;
          CFG_CAND_Y: cand_y = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) rank_point(in_point_x, in_point_y, in_final_point);
      if (out_valid && !out_stall) begin
        if (neighbors_due.size() == 0) begin
          $display("%0t: unexpected neighbor item: x %h y %h dist %h rank %0d end %b",
                   $time, out_neighbor_x, out_neighbor_y, out_neighbor_dist_sq,
                   out_rank, out_end_of_list);
          errors++;
        end else begin
          n = neighbors_due.pop_front();
          if (out_neighbor_x !== n.x)
            report("neighbor_x", DIST_W'(n.x), DIST_W'(out_neighbor_x));
          if (out_neighbor_y !== n.y)
            report("neighbor_y", DIST_W'(n.y), DIST_W'(out_neighbor_y));
          if (out_neighbor_dist_sq !== n.dsq)
            report("neighbor_dist_sq", n.dsq, out_neighbor_dist_sq);
          if (out_rank !== n.rank)
            report("rank", DIST_W'(n.rank), DIST_W'(out_rank));
          if (out_end_of_list !== n.eol)
            report("end_of_list", DIST_W'(n.eol), DIST_W'(out_end_of_list));
        end
      end
    end
    pending_count <= neighbors_due.size();
  end

endmodule : nfps_checker

`default_nettype wire

[tb/nearest_four_point_selector_test.sv]
// ----------------------------------------------------------------------------
// nearest_four_point_selector_test
// Stimulus and verdict for the nearest four point selector.
// ----------------------------------------------------------------------------
// A directed part covers zero and maximum distances, ties, drops from a full
// list, insertion at the head and single point sets under extreme candidate
// points. Random sets of points follow, clustered around the candidate so
// that ties and zero distances stay common, with the candidate rewritten
// between sets. Both channels idle at random; one phase holds the neighbor
// side off long enough to stall the point input. The checker module predicts
// and compares; this module only drives and reports.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_four_point_selector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nfps_pkg::*;

  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 90;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [COORD_W-1:0]   in_point_x = '0;
  logic [COORD_W-1:0]   in_point_y = '0;
  logic                 in_final_point = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CAND_X;
  logic [COORD_W-1:0]   cfg_data = '0;
  wire logic            in_stall;
  wire logic            out_valid;
  wire logic [COORD_W-1:0] out_neighbor_x;
  wire logic [COORD_W-1:0] out_neighbor_y;
  wire logic [DIST_W-1:0]  out_neighbor_dist_sq;
  wire logic [RANK_W-1:0]  out_rank;
  wire logic            out_end_of_list;
  wire logic            cfg_ready;
  int                   fail_count;
  int                   pending_count;

  // Test state; calm and hold_left are shared between sender and receiver
  bit                   calm = 1'b0;
  int                   hold_left = 0;
  int                   cycle_count = 0;
  logic [COORD_W-1:0]   cur_cx = '0;
  logic [COORD_W-1:0]   cur_cy = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_four_point_selector uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_final_point       (in_final_point),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_neighbor_x       (out_neighbor_x),
    .out_neighbor_y       (out_neighbor_y),
    .out_neighbor_dist_sq (out_neighbor_dist_sq),
    .out_rank             (out_rank),
    .out_end_of_list      (out_end_of_list),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  nfps_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_final_point       (in_final_point),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_neighbor_x       (out_neighbor_x),
    .out_neighbor_y       (out_neighbor_y),
    .out_neighbor_dist_sq (out_neighbor_dist_sq),
    .out_rank             (out_rank),
    .out_end_of_list      (out_end_of_list),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .fail_count           (fail_count),
    .pending_count        (pending_count)
  );

  // Offer one point item and hold it until taken
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic fin);
    if (!calm) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_final_point <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and let every queued neighbor come out
  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both candidate registers back to back; only called while idle
  task automatic set_candidate(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CAND_X;
    cfg_data <= x;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_CAND_Y;
    cfg_data <= y;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_cx = x;
    cur_cy = y;
  endtask

  // Mostly uniform, often near the candidate, sometimes at the rails
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] centre);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 16'hFFFF));
      5, 6, 7:       v = int'(centre) + int'($urandom_range(0, 8)) - 4;
      8:             v = $urandom_range(0, 1) ? int'(COORD_MAX) : 0;
      default:       v = int'(centre);
    endcase
    if (v < 0) v = 0;
    if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] pick_candidate();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return COORD_MAX;
      default: return COORD_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Neighbor side: random stalls, or a long hold when the sender asks
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 30);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int items;
    int set_no;
    int len;
    int i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Candidate at reset value: zero distance appended, ties, full list drops
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0001, 1'b0);
    send_point(16'h0001, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(16'h0000, 16'h0002, 1'b0);
    send_point(COORD_MAX, 16'h0000, 1'b1);
    wait_drained();

    // Candidate at the top corner: maximum distance, insert at head
    set_candidate(COORD_MAX, COORD_MAX);
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(COORD_MAX, 16'h0000, 1'b0);
    send_point(16'h0000, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(16'hFFFE, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b1);
    // set of a single point
    send_point(16'h8000, 16'h8000, 1'b1);
    wait_drained();

    // Mixed corner: each point beats the whole list
    set_candidate(16'h0000, COORD_MAX);
    send_point(16'h1000, COORD_MAX, 1'b0);
    send_point(16'h0800, COORD_MAX, 1'b0);
    send_point(16'h0400, COORD_MAX, 1'b0);
    send_point(16'h0200, COORD_MAX, 1'b0);
    send_point(16'h0100, COORD_MAX, 1'b1);

    // Long neighbor hold while sets keep coming: input must stall
    calm = 1'b1;
    hold_left = HOLD_CYCLES;
    for (set_no = 0; set_no < 3; set_no++) begin
      for (i = 0; i < 3; i++) send_point(pick_coord(cur_cx), pick_coord(cur_cy), i == 2);
    end
    calm = 1'b0;
    wait_drained();

    // Random sets, candidate rewritten every fourth set
    items = 0;
    set_no = 0;
    while (items < RANDOM_ITEMS) begin
      if (set_no % 4 == 3) begin
        wait_drained();
        set_candidate(pick_candidate(), pick_candidate());
      end
      calm = (items >= 40 && items < 70);
      len = $urandom_range(1, 9);
      for (i = 0; i < len; i++) begin
        send_point(pick_coord(cur_cx), pick_coord(cur_cy), i == len - 1);
        items++;
      end
      set_no++;
    end
    calm = 1'b0;
    wait_drained();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : nearest_four_point_selector_test

`default_nettype wire
